@@ rtl/straight_alpha_over_blend_core_macros.svh @@
// Assertion macros shared by the alpha-over blend RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef STRAIGHT_ALPHA_OVER_BLEND_CORE_MACROS_SVH
`define STRAIGHT_ALPHA_OVER_BLEND_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SAOB_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAOB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/saob_pkg.sv @@
// Types, constants and register indexes for the alpha-over blend core.
// No dependencies; used by saob_div_step and the top level.
`default_nettype none

package saob_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned NUM_W     = 25;  // blend numerator, < 2^25
    localparam int unsigned DVS_W     = 16;  // oa * 255
    localparam int unsigned QUO_W     = 9;   // overflow bit + 8 quotient bits
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam int unsigned PRE_STG   = 3;   // stages ahead of the divider
    localparam int unsigned NUM_STG   = PRE_STG + DIV_STEPS + 1;

    localparam logic [CHAN_W-1:0] ALPHA_MAX  = 8'd255;
    localparam logic [16:0]       ROUND_HALF = 17'd127;

    localparam logic [13:0] FRAME_WIDTH_RST  = 14'd240;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd240;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [7:0]         src_red;
        logic [7:0]         src_green;
        logic [7:0]         src_blue;
        logic [7:0]         src_alpha;
        logic [7:0]         dst_red;
        logic [7:0]         dst_green;
        logic [7:0]         dst_blue;
        logic [7:0]         dst_alpha;
    } pix_word_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } res_word_t;

    // Per-item control carried alongside the datapath.
    typedef struct packed {
        logic                   we;
        logic                   blend;
        logic [3:0][CHAN_W-1:0] byp;   // color when not blending: r, g, b, a
        logic [CHAN_W-1:0]      oa;
    } side_t;

    // One divider lane set: three color channels share the divisor.
    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [DVS_W-1:0]      dvs;
        logic [2:0][QUO_W-1:0] quo;
    } div_lane_t;

endpackage

`default_nettype wire

@@ rtl/saob_div_step.sv @@
// One registered restoring-division step for the three color channels.
// Depends on saob_pkg (div_lane_t, widths).
`default_nettype none

module saob_div_step
    import saob_pkg::*;
#(
    parameter int unsigned SHIFT = QUO_W - 1
)
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_lane_t lane_in,
    output div_lane_t      lane_reg
);

    logic [NUM_W-1:0] trial;
    div_lane_t        lane_next;

    always_comb
    begin
        trial     = NUM_W'(lane_in.dvs) << SHIFT;
        lane_next = lane_in;
        for (int k = 0; k < 3; k++)
        begin
            if (lane_in.rem[k] >= trial)
            begin
                lane_next.rem[k] = lane_in.rem[k] - trial;
                lane_next.quo[k] = {lane_in.quo[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                lane_next.quo[k] = {lane_in.quo[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/straight_alpha_over_blend_core.sv @@
// Straight-alpha source-over compositor, one pixel word per clock when not stalled.
// 13 register stages from input accept to result valid.
// Throughput: one word per cycle when res_stall is low; the 9-step divider is pipelined.
// Each stage holds its word until the next frees up, so stalls lose nothing.
// Reset (rst_n low, async): all stage valids cleared, frame set to 240 x 240.
`default_nettype none

module straight_alpha_over_blend_core
    import saob_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire cfg_idx_t    cfg_addr,
    input  wire logic [15:0] cfg_wdata,

    // pixel word in
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire pix_word_t   pix,

    // result word out
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_word_t        res
);

`include "straight_alpha_over_blend_core_macros.svh"

    // ------------------------------------------------------------------
    // Frame size registers
    // ------------------------------------------------------------------
    logic [13:0] frame_width_reg;
    logic [15:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[13:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads. Stage NUM_STG-1 is the output register.
    // ------------------------------------------------------------------
    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] en;
    logic [NUM_STG-1:0] vld_in;

    assign en[NUM_STG-1] = !vld_reg[NUM_STG-1] || !res_stall;

    for (genvar k = 0; k < NUM_STG - 1; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign vld_in = {vld_reg[NUM_STG-2:0], pix_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign pix_stall = !en[0];
    assign res_valid = vld_reg[NUM_STG-1];

    // ------------------------------------------------------------------
    // Stage 1: decisions, inverse alpha, first products
    // ------------------------------------------------------------------
    logic                   x_ok;
    logic                   y_ok;
    logic                   we_s0;
    logic                   copy_s0;
    logic [CHAN_W-1:0]      inv_s0;
    logic [2:0][CHAN_W-1:0] src_c;
    logic [2:0][CHAN_W-1:0] dst_c;
    side_t                  side_s0;

    side_t                  side1_reg;
    logic [CHAN_W-1:0]      sa1_reg;
    logic [2:0][CHAN_W-1:0] dc1_reg;
    logic [15:0]            dainv1_reg;
    logic [2:0][15:0]       sprod1_reg;

    always_comb
    begin
        src_c   = {pix.src_blue, pix.src_green, pix.src_red};
        dst_c   = {pix.dst_blue, pix.dst_green, pix.dst_red};
        // negative coordinates are outside; otherwise compare magnitudes
        x_ok    = !pix.pixel_x[15] && ({1'b0, pix.pixel_x[14:0]} < {2'b00, frame_width_reg});
        y_ok    = !pix.pixel_y[15] && ({1'b0, pix.pixel_y[14:0]} < frame_height_reg);
        we_s0   = (pix.src_alpha != '0) && x_ok && y_ok;
        copy_s0 = (pix.src_alpha == ALPHA_MAX) || (pix.dst_alpha == '0);
        inv_s0  = ALPHA_MAX - pix.src_alpha;

        side_s0.we    = we_s0;
        side_s0.blend = we_s0 && !copy_s0;
        side_s0.oa    = '0;
        if (we_s0)
        begin
            side_s0.byp = {pix.src_alpha, pix.src_blue, pix.src_green, pix.src_red};
        end
        else
        begin
            side_s0.byp = {pix.dst_alpha, pix.dst_blue, pix.dst_green, pix.dst_red};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side1_reg  <= side_s0;
            sa1_reg    <= pix.src_alpha;
            dc1_reg    <= dst_c;
            dainv1_reg <= pix.dst_alpha * inv_s0;
            for (int k = 0; k < 3; k++)
            begin
                sprod1_reg[k] <= src_c[k] * pix.src_alpha;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: output alpha (divide by 255 as shift-add), channel terms
    // ------------------------------------------------------------------
    logic [16:0]       dq_a;
    logic [16:0]       dq_b;
    logic [8:0]        oa_wide;
    side_t             side_s1;

    side_t             side2_reg;
    logic [2:0][23:0]  sterm2_reg;
    logic [2:0][23:0]  dterm2_reg;

    always_comb
    begin
        // exact floor((v + 127) / 255), v / 255 rounded, for v < 65408
        dq_a    = {1'b0, dainv1_reg} + ROUND_HALF;
        dq_b    = dq_a + (dq_a >> 8) + 17'd1;
        oa_wide = {1'b0, sa1_reg} + {1'b0, dq_b[15:8]};
        side_s1    = side1_reg;
        side_s1.oa = oa_wide[CHAN_W-1:0];   // never exceeds 255
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side2_reg <= side_s1;
            for (int k = 0; k < 3; k++)
            begin
                sterm2_reg[k] <= {sprod1_reg[k], 8'd0} - {8'd0, sprod1_reg[k]};
                dterm2_reg[k] <= dc1_reg[k] * dainv1_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator sum and divisor oa*255
    // ------------------------------------------------------------------
    logic [14:0]  oa_127;
    div_lane_t    lane_s2;

    div_lane_t    lane_reg [DIV_STEPS+1];
    side_t        side_reg [PRE_STG+DIV_STEPS];

    always_comb
    begin
        oa_127      = {side2_reg.oa, 7'd0} - {7'd0, side2_reg.oa};
        lane_s2.dvs = {side2_reg.oa, 8'd0} - {8'd0, side2_reg.oa};
        for (int k = 0; k < 3; k++)
        begin
            lane_s2.rem[k] = NUM_W'(sterm2_reg[k]) + NUM_W'(dterm2_reg[k])
                           + NUM_W'(oa_127);
            lane_s2.quo[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            lane_reg[0]         <= lane_s2;
            side_reg[PRE_STG-1] <= side2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: first step flags a quotient of 256 or more (saturate),
    // the next eight produce quotient bits 7..0.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        saob_div_step #(
            .SHIFT (DIV_STEPS - 1 - j)
        ) u_step (
            .clk      (clk),
            .en       (en[PRE_STG+j]),
            .lane_in  (lane_reg[j]),
            .lane_reg (lane_reg[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[PRE_STG+j])
            begin
                side_reg[PRE_STG+j] <= side_reg[PRE_STG-1+j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    side_t                  side_fin;
    logic [2:0][CHAN_W-1:0] mix_c;
    res_word_t              res_next;
    res_word_t              res_reg;

    always_comb
    begin
        side_fin = side_reg[PRE_STG+DIV_STEPS-1];
        for (int k = 0; k < 3; k++)
        begin
            mix_c[k] = lane_reg[DIV_STEPS].quo[k][QUO_W-1]
                     ? ALPHA_MAX
                     : lane_reg[DIV_STEPS].quo[k][CHAN_W-1:0];
        end
        res_next.write_enable = side_fin.we;
        if (side_fin.blend)
        begin
            res_next.out_red   = mix_c[0];
            res_next.out_green = mix_c[1];
            res_next.out_blue  = mix_c[2];
            res_next.out_alpha = side_fin.oa;
        end
        else
        begin
            res_next.out_red   = side_fin.byp[0];
            res_next.out_green = side_fin.byp[1];
            res_next.out_blue  = side_fin.byp[2];
            res_next.out_alpha = side_fin.byp[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STG-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // input backs up only when a finished word is stuck at the output
    `SAOB_ASSERT_NOW(a_stall_origin, clk, rst_n, pix_stall, res_valid && res_stall, "input stalled without output backpressure")

    // any written pixel has nonzero alpha (sa >= 1 on every write path)
    `SAOB_ASSERT_NOW(a_write_alpha, clk, rst_n, res_valid && res.write_enable, res.out_alpha != '0, "written pixel has zero alpha")

    // a word taken at the output with nothing behind it leaves it empty
    `SAOB_ASSERT_NEXT(a_drain, clk, rst_n, res_valid && !res_stall && !vld_reg[NUM_STG-2], !res_valid, "output word repeated")

endmodule

`default_nettype wire

@@ bench/straight_alpha_over_blend_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the straight-alpha source-over compositor core.
// Depends on saob_pkg and straight_alpha_over_blend_core; predicts every result word.

module straight_alpha_over_blend_core_tb;
    import saob_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;     // pipeline is 13 deep
    localparam int unsigned HOLD_CYCLES  = 120;    // long receiver hold-off
    localparam int unsigned RAND_PER_PHASE = 170;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the frame registers, blend predictor and the
    // queue of result words still owed by the block.
    // ------------------------------------------------------------------
    class over_scoreboard;
        logic [13:0] frame_width;
        logic [15:0] frame_height;
        res_word_t   owed_words[$];
        int          errors;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            errors       = 0;
        endfunction

        // register writes keep only the implemented bits
        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            if (idx == CFG_FRAME_WIDTH)
                frame_width = val[13:0];
            else
                frame_height = val;
        endfunction

        function logic [7:0] mix(int unsigned sc, int unsigned dc, int unsigned sa,
                                 int unsigned da, int unsigned inv, int unsigned oa);
            int unsigned num;
            int unsigned q;
            num = sc * sa * 255 + dc * da * inv + oa * 127;
            q   = num / (oa * 255);
            // rounding can reach 256; clamp instead of wrapping
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function res_word_t predict_over(pix_word_t p);
            res_word_t   r;
            logic [15:0] xr;
            logic [15:0] yr;
            logic        in_frame;
            int unsigned sa;
            int unsigned da;
            int unsigned inv;
            int unsigned oa;
            xr = p.pixel_x;
            yr = p.pixel_y;
            sa = p.src_alpha;
            da = p.dst_alpha;
            in_frame = !xr[15] && !yr[15] && (xr < {2'b00, frame_width})
                       && (yr < frame_height);
            if (sa == 0 || !in_frame)
            begin
                // no write: destination passes through
                r.write_enable = 1'b0;
                r.out_red      = p.dst_red;
                r.out_green    = p.dst_green;
                r.out_blue     = p.dst_blue;
                r.out_alpha    = p.dst_alpha;
            end
            else if (sa == 255 || da == 0)
            begin
                // opaque source or empty destination: straight copy
                r.write_enable = 1'b1;
                r.out_red      = p.src_red;
                r.out_green    = p.src_green;
                r.out_blue     = p.src_blue;
                r.out_alpha    = p.src_alpha;
            end
            else
            begin
                inv = 255 - sa;
                oa  = sa + (da * inv + 127) / 255;
                r.write_enable = 1'b1;
                r.out_red      = mix(p.src_red, p.dst_red, sa, da, inv, oa);
                r.out_green    = mix(p.src_green, p.dst_green, sa, da, inv, oa);
                r.out_blue     = mix(p.src_blue, p.dst_blue, sa, da, inv, oa);
                r.out_alpha    = oa[7:0];
            end
            return r;
        endfunction

        function void note_pixel(pix_word_t p);
            owed_words.push_back(predict_over(p));
        endfunction

        function void cmp(string name, logic [7:0] exp, logic [7:0] act);
            if (exp !== act)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(res_word_t r);
            res_word_t e;
            if (owed_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got %h", $time, r);
                errors++;
                return;
            end
            e = owed_words.pop_front();
            cmp("write_enable", {7'b0, e.write_enable}, {7'b0, r.write_enable});
            cmp("out_red", e.out_red, r.out_red);
            cmp("out_green", e.out_green, r.out_green);
            cmp("out_blue", e.out_blue, r.out_blue);
            cmp("out_alpha", e.out_alpha, r.out_alpha);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the driven ones are known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    cfg_idx_t    cfg_addr  = CFG_FRAME_WIDTH;
    logic [15:0] cfg_wdata = '0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    pix_word_t   pix_in    = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_word_t   res_out;

    over_scoreboard board = new();

    // idle percentages, changed by the stimulus between phases
    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 67;
    int unsigned cycles        = 0;

    straight_alpha_over_blend_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix_in),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL straight_alpha_over_blend_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side. Handshake sampled right after the edge, so the values
    // seen are the ones the edge used. Two long hold-offs are counted here
    // while the sender keeps offering words, to back the pipe up.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int unsigned taken;
        int unsigned hold_left;
        taken     = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                board.check_result(res_out);
                taken++;
                if (taken == 60 || taken == 330)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Offer one pixel word, with random idle cycles ahead of it. Valid is
    // only dropped on a step where no new word goes out.
    task automatic send_pixel(input pix_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_in    <= w;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        board.note_pixel(w);
    endtask

    // Stop sending and let every owed word come back, plus pipeline slack.
    task automatic drain;
        pix_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both frame registers, back to back; block must be idle.
    task automatic write_frame(input logic [15:0] w, input logic [15:0] h);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= CFG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(CFG_FRAME_WIDTH, w);
        board.set_reg(CFG_FRAME_HEIGHT, h);
        @(posedge clk);
    endtask

    function automatic pix_word_t mk(int x, int y, int sr, int sg, int sb, int sa,
                                     int dr, int dg, int db, int da);
        pix_word_t p;
        p.pixel_x   = 16'(x);
        p.pixel_y   = 16'(y);
        p.src_red   = 8'(sr);
        p.src_green = 8'(sg);
        p.src_blue  = 8'(sb);
        p.src_alpha = 8'(sa);
        p.dst_red   = 8'(dr);
        p.dst_green = 8'(dg);
        p.dst_blue  = 8'(db);
        p.dst_alpha = 8'(da);
        return p;
    endfunction

    // Mostly inside the frame, a fair share on the edges, rest anywhere.
    function automatic logic [15:0] pick_coord(int unsigned span);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 50)
            return (span == 0) ? 16'd0 : 16'($urandom_range(span - 1));
        if (k < 75)
        begin
            case ($urandom_range(3))
                0:       return 16'hFFFF;
                1:       return 16'd0;
                2:       return 16'(span - 1);
                default: return 16'(span);
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_alpha();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 15) return 8'd0;
        if (k < 30) return 8'd255;
        if (k < 35) return 8'd1;
        if (k < 40) return 8'd254;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_chan();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 8)  return 8'd0;
        if (k < 16) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic pix_word_t random_pixel();
        pix_word_t p;
        p.pixel_x   = pick_coord(board.frame_width);
        p.pixel_y   = pick_coord(board.frame_height);
        p.src_red   = pick_chan();
        p.src_green = pick_chan();
        p.src_blue  = pick_chan();
        p.src_alpha = pick_alpha();
        p.dst_red   = pick_chan();
        p.dst_green = pick_chan();
        p.dst_blue  = pick_chan();
        p.dst_alpha = pick_alpha();
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed, reset frame of 240 x 240 ---
        send_pixel(mk(10, 10, 40, 50, 60, 0, 1, 2, 3, 4));            // clear source
        send_pixel(mk(10, 10, 11, 22, 33, 255, 90, 80, 70, 60));      // opaque source
        send_pixel(mk(20, 30, 11, 22, 33, 100, 90, 80, 70, 0));       // empty destination
        send_pixel(mk(5, 6, 200, 100, 0, 1, 10, 20, 255, 255));       // faintest blend
        send_pixel(mk(5, 6, 0, 128, 255, 254, 255, 0, 77, 1));        // strongest blend
        send_pixel(mk(7, 8, 128, 64, 32, 128, 16, 8, 4, 128));        // mid blend
        send_pixel(mk(1, 1, 255, 255, 255, 128, 255, 255, 255, 1));   // rounds to 256
        send_pixel(mk(-1, 0, 1, 2, 3, 200, 4, 5, 6, 7));              // left of frame
        send_pixel(mk(0, -1, 1, 2, 3, 200, 4, 5, 6, 7));              // above frame
        send_pixel(mk(239, 239, 9, 8, 7, 200, 6, 5, 4, 3));           // last pixel
        send_pixel(mk(240, 0, 9, 8, 7, 200, 6, 5, 4, 3));             // one past width
        send_pixel(mk(0, 240, 9, 8, 7, 200, 6, 5, 4, 3));             // one past height
        send_pixel(mk(-32768, -32768, 255, 255, 255, 255, 0, 0, 0, 0));
        send_pixel(mk(32767, 32767, 255, 255, 255, 255, 0, 0, 0, 0));
        send_pixel(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(mk(0, 0, 255, 255, 255, 255, 255, 255, 255, 255));
        drain();

        // zero-sized frame; width write has only bit 14 set, masks to zero
        write_frame(16'h4000, 16'h0000);
        send_pixel(mk(0, 0, 10, 20, 30, 255, 1, 2, 3, 4));
        send_pixel(mk(5, 5, 10, 20, 30, 100, 1, 2, 3, 50));
        drain();

        // largest frame, width write carries the unused upper bits
        write_frame(16'hFFFF, 16'hFFFF);
        send_pixel(mk(16382, 32767, 10, 20, 30, 100, 1, 2, 3, 50));
        send_pixel(mk(16383, 100, 10, 20, 30, 100, 1, 2, 3, 50));
        send_pixel(mk(32767, 0, 10, 20, 30, 100, 1, 2, 3, 50));
        drain();

        // single-pixel frame
        write_frame(16'd1, 16'd1);
        send_pixel(mk(0, 0, 10, 20, 30, 100, 1, 2, 3, 50));
        send_pixel(mk(1, 0, 10, 20, 30, 100, 1, 2, 3, 50));
        send_pixel(mk(0, 1, 10, 20, 30, 100, 1, 2, 3, 50));
        drain();

        // --- random phases, each with its own frame and idle mix ---
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 67;
                    write_frame({2'($urandom), 14'($urandom_range(1, 320))},
                                16'($urandom_range(1, 320)));
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 32;
                    write_frame(16'd2, 16'd65535);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_frame(16'($urandom), 16'($urandom));
                end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++)
                send_pixel(random_pixel());
            drain();
        end

        if (board.errors == 0)
            $display("PASS straight_alpha_over_blend_core");
        else
            $display("FAIL straight_alpha_over_blend_core");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/saob_pkg.sv
rtl/saob_div_step.sv
rtl/straight_alpha_over_blend_core.sv
bench/straight_alpha_over_blend_core_tb.sv
